@@ rtl/core/mctf_pkg.sv @@
`default_nettype none
package mctf_pkg;

    localparam int LINE_BYTES  = 32;
    localparam int FLUSH_LIMIT = 8;
    localparam int HEAD_DEPTH  = LINE_BYTES - FLUSH_LIMIT - 1;
    localparam int QUEUE_DEPTH = 4;

    localparam int POS_W   = $clog2(LINE_BYTES);
    localparam int OFF_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int HIDX_W  = $clog2(HEAD_DEPTH);
    localparam int HCNT_W  = $clog2(HEAD_DEPTH + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [POS_W:0]  LINE_BYTES_V  = (POS_W + 1)'(LINE_BYTES);
    localparam logic [POS_W:0]  FLUSH_LIMIT_V = (POS_W + 1)'(FLUSH_LIMIT);
    localparam logic [HCNT_W-1:0] HEAD_DEPTH_V = HCNT_W'(HEAD_DEPTH);
    localparam logic [QPTR_W:0] QUEUE_DEPTH_V = (QPTR_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REGION_START = 2'd0,
        REGION_DATA  = 2'd1,
        REGION_NULL  = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_FLUSH = 2'd1,
        TAIL_PAD   = 2'd2
    } t_tail;

    typedef enum logic [1:0] {
        BK_MAIN  = 2'd0,
        BK_FLUSH = 2'd1,
        BK_PAD   = 2'd2
    } t_back_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_region           region;
        logic [OFF_W-1:0]  offset;
        t_tail             tail;
        logic [POS_W-1:0]  pad_start;
        logic [HIDX_W-1:0] pad_last;
        logic [HCNT_W-1:0] head_lim;
    } t_job;

    typedef struct packed {
        logic              pad_done;
        logic [HIDX_W-1:0] rd_idx;
    } t_back_ctl;

    function automatic logic [OFF_W-1:0] to_offset(input logic [POS_W:0] pos);
        return pos[OFF_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mailbox_cacheline_tx_framer_top.sv @@
// Mailbox cache-line transmit framer. Each packet byte becomes one mailbox byte
// write: bytes of the first 32-byte line target the packet-start region, later
// lines the packet-data region, each tagged with its offset in the line. A packet
// ending on a partial line of 9 or more bytes is followed by padding writes that
// replay the packet's first bytes, or zeros past its end, up to the line end; one
// of 8 bytes or fewer is followed by a single null-region flush write. Packet
// bytes pass at one item per clock unless stalled through a 4-entry queue into a
// registered output stage; the output side emits one write per cycle unless
// i_stall holds it, and a packet end adds one flush write or up to 23 padding
// writes. While a padding run is pending or being emitted, the input stalls,
// since the run reads the head store that the next packet would overwrite.
`default_nettype none
module mailbox_cacheline_tx_framer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [mctf_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                        i_end_of_packet,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_region,
    output logic [mctf_pkg::OFF_W-1:0]       o_line_offset,
    output logic [mctf_pkg::BYTE_W-1:0]      o_write_byte,
    output logic                             o_is_padding,
    output logic                             o_run_last
);

    logic                        q_full;
    logic                        push;
    logic                        pop;
    logic                        q_valid;
    mctf_pkg::t_job              job_in;
    mctf_pkg::t_job              job_out;
    mctf_pkg::t_back_ctl         back_ctl;
    logic [mctf_pkg::BYTE_W-1:0] head_rd_data;

    mctf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_job           (job_in),
        .i_back_ctl      (back_ctl),
        .o_head_rd_data  (head_rd_data)
    );

    mctf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    mctf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_back_ctl     (back_ctl),
        .i_head_rd_data (head_rd_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_region       (o_region),
        .o_line_offset  (o_line_offset),
        .o_write_byte   (o_write_byte),
        .o_is_padding   (o_is_padding),
        .o_run_last     (o_run_last)
    );

endmodule
`default_nettype wire

@@ rtl/core/mctf_front.sv @@
`default_nettype none
module mctf_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [mctf_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                         i_end_of_packet,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output mctf_pkg::t_job                    o_job,
    input  wire mctf_pkg::t_back_ctl          i_back_ctl,
    output logic [mctf_pkg::BYTE_W-1:0]       o_head_rd_data
);

    logic [mctf_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_first, n_first;
    logic [mctf_pkg::HCNT_W-1:0] r_head_cnt, n_head_cnt;
    logic                        r_pad_busy, n_pad_busy;
    logic [mctf_pkg::BYTE_W-1:0] r_head [mctf_pkg::HEAD_DEPTH];

    logic [mctf_pkg::POS_W:0]    filled;
    logic [mctf_pkg::POS_W:0]    pad_last_full;
    logic                        wrap;
    logic                        head_wr;
    logic [mctf_pkg::HCNT_W-1:0] head_lim;

    assign o_stall = i_q_full || r_pad_busy;
    assign o_push  = i_valid && !o_stall;

    assign filled        = {1'b0, r_pos} + 1'b1;
    assign wrap          = (filled == mctf_pkg::LINE_BYTES_V);
    assign pad_last_full = mctf_pkg::LINE_BYTES_V - filled - 1'b1;
    assign head_wr       = (r_head_cnt < mctf_pkg::HEAD_DEPTH_V);
    assign head_lim      = head_wr ? r_head_cnt + 1'b1 : r_head_cnt;

    assign o_head_rd_data = r_head[i_back_ctl.rd_idx];

    always_comb begin
        o_job.data      = i_data_byte;
        o_job.region    = r_first ? mctf_pkg::REGION_START : mctf_pkg::REGION_DATA;
        o_job.offset    = mctf_pkg::to_offset({1'b0, r_pos});
        o_job.pad_start = filled[mctf_pkg::POS_W-1:0];
        o_job.pad_last  = pad_last_full[mctf_pkg::HIDX_W-1:0];
        o_job.head_lim  = head_lim;
        priority if (!i_end_of_packet || wrap) begin
            o_job.tail = mctf_pkg::TAIL_NONE;
        end else if (filled <= mctf_pkg::FLUSH_LIMIT_V) begin
            o_job.tail = mctf_pkg::TAIL_FLUSH;
        end else begin
            o_job.tail = mctf_pkg::TAIL_PAD;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_first    = r_first;
        n_head_cnt = r_head_cnt;
        n_pad_busy = r_pad_busy;
        if (i_back_ctl.pad_done) begin
            n_pad_busy = 1'b0;
        end
        if (o_push) begin
            n_head_cnt = head_lim;
            if (i_end_of_packet) begin
                n_pos      = '0;
                n_first    = 1'b1;
                n_head_cnt = '0;
                n_pad_busy = (o_job.tail == mctf_pkg::TAIL_PAD);
            end else if (wrap) begin
                n_pos   = '0;
                n_first = 1'b0;
            end else begin
                n_pos = filled[mctf_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_first    <= 1'b1;
            r_head_cnt <= '0;
            r_pad_busy <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_first    <= n_first;
            r_head_cnt <= n_head_cnt;
            r_pad_busy <= n_pad_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push && head_wr) begin
            r_head[r_head_cnt[mctf_pkg::HIDX_W-1:0]] <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mctf_queue.sv @@
`default_nettype none
module mctf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mctf_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output mctf_pkg::t_job      o_job
);

    mctf_pkg::t_job              r_mem [mctf_pkg::QUEUE_DEPTH];
    logic [mctf_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [mctf_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [mctf_pkg::QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == mctf_pkg::QUEUE_DEPTH_V);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mctf_back.sv @@
`default_nettype none
module mctf_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire mctf_pkg::t_job              i_job,
    output logic                             o_pop,
    output mctf_pkg::t_back_ctl              o_back_ctl,
    input  wire logic [mctf_pkg::BYTE_W-1:0] i_head_rd_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_region,
    output logic [mctf_pkg::OFF_W-1:0]       o_line_offset,
    output logic [mctf_pkg::BYTE_W-1:0]      o_write_byte,
    output logic                             o_is_padding,
    output logic                             o_run_last
);

    mctf_pkg::t_back_state       r_state, n_state;
    logic [mctf_pkg::HIDX_W-1:0] r_idx, n_idx;
    logic [mctf_pkg::HIDX_W-1:0] r_last_idx, n_last_idx;
    logic [mctf_pkg::POS_W-1:0]  r_pad_pos, n_pad_pos;
    logic [mctf_pkg::HCNT_W-1:0] r_lim, n_lim;

    logic                        r_out_valid, n_out_valid;
    mctf_pkg::t_region           r_region, n_region;
    logic [mctf_pkg::OFF_W-1:0]  r_offset, n_offset;
    logic [mctf_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic                        r_pad, n_pad;
    logic                        r_last, n_last;

    logic adv;
    logic pad_end;

    assign adv     = !r_out_valid || !i_stall;
    assign o_pop   = (r_state == mctf_pkg::BK_MAIN) && adv && i_q_valid;
    assign pad_end = (r_state == mctf_pkg::BK_PAD) && adv && (r_idx == r_last_idx);

    assign o_back_ctl.pad_done = pad_end;
    assign o_back_ctl.rd_idx   = r_idx;

    assign o_valid       = r_out_valid;
    assign o_region      = r_region;
    assign o_line_offset = r_offset;
    assign o_write_byte  = r_byte;
    assign o_is_padding  = r_pad;
    assign o_run_last    = r_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mctf_pkg::BK_MAIN: begin
                if (o_pop) begin
                    unique case (i_job.tail)
                        mctf_pkg::TAIL_FLUSH: n_state = mctf_pkg::BK_FLUSH;
                        mctf_pkg::TAIL_PAD:   n_state = mctf_pkg::BK_PAD;
                        default:              n_state = mctf_pkg::BK_MAIN;
                    endcase
                end
            end
            mctf_pkg::BK_FLUSH: begin
                if (adv) begin
                    n_state = mctf_pkg::BK_MAIN;
                end
            end
            mctf_pkg::BK_PAD: begin
                if (pad_end) begin
                    n_state = mctf_pkg::BK_MAIN;
                end
            end
            default: n_state = mctf_pkg::BK_MAIN;
        endcase
    end

    always_comb begin
        n_out_valid = !adv;
        n_region    = r_region;
        n_offset    = r_offset;
        n_byte      = r_byte;
        n_pad       = r_pad;
        n_last      = r_last;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_pad_pos   = r_pad_pos;
        n_lim       = r_lim;
        unique case (r_state)
            mctf_pkg::BK_MAIN: begin
                if (o_pop) begin
                    n_out_valid = 1'b1;
                    n_region    = i_job.region;
                    n_offset    = i_job.offset;
                    n_byte      = i_job.data;
                    n_pad       = 1'b0;
                    n_last      = (i_job.tail == mctf_pkg::TAIL_NONE);
                    n_idx       = '0;
                    n_last_idx  = i_job.pad_last;
                    n_pad_pos   = i_job.pad_start;
                    n_lim       = i_job.head_lim;
                end
            end
            mctf_pkg::BK_FLUSH: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_region    = mctf_pkg::REGION_NULL;
                    n_offset    = '0;
                    n_byte      = '0;
                    n_pad       = 1'b0;
                    n_last      = 1'b1;
                end
            end
            mctf_pkg::BK_PAD: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_region    = mctf_pkg::REGION_DATA;
                    n_offset    = mctf_pkg::to_offset({1'b0, r_pad_pos});
                    n_byte      = (mctf_pkg::HCNT_W'(r_idx) < r_lim) ? i_head_rd_data : '0;
                    n_pad       = 1'b1;
                    n_last      = (r_idx == r_last_idx);
                    n_idx       = r_idx + 1'b1;
                    n_pad_pos   = r_pad_pos + 1'b1;
                end
            end
            default: begin
                n_out_valid = !adv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mctf_pkg::BK_MAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_region   <= n_region;
        r_offset   <= n_offset;
        r_byte     <= n_byte;
        r_pad      <= n_pad;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_pad_pos  <= n_pad_pos;
        r_lim      <= n_lim;
    end

endmodule
`default_nettype wire
